// File: rtl/nlp_pkg.sv
package nlp_pkg;

  // Parse phases of the literal scanner
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_ZERO_U = 3'd1;
  localparam logic [2:0] PH_ZERO_S = 3'd2;
  localparam logic [2:0] PH_SIGN   = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_BIN    = 3'd5;
  localparam logic [2:0] PH_DEC    = 3'd6;
  localparam logic [2:0] PH_KILO   = 3'd7;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LONG    = 3'd1,
    ST_BADBIN  = 3'd2,
    ST_SIGN    = 3'd3,
    ST_PERCENT = 3'd4,
    ST_LETTER  = 3'd5,
    ST_NOTNUM  = 3'd6
  } status_e;

  localparam logic [4:0] HEX_LIMIT = 5'd11;
  localparam logic [4:0] BIN_LIMIT = 5'd18;
  localparam logic [4:0] DEC_LIMIT = 5'd8;
  localparam logic [4:0] POS_MAX   = 5'd31;
  localparam int unsigned KILO_SHIFT = 10;

  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_K_UP   = 8'h4B;
  localparam logic [7:0] CH_K_LO   = 8'h6B;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [7:0]  bad_char;
  } result_t;

endpackage

// File: rtl/numeric_literal_parser.sv
// Integer literal parser for assembler tokens.
// Slave stream: one character per transaction in s_axis_tdata_i, with
// s_axis_tlast_i on the final character of the token. Hex ($ or 0x),
// binary (%) and decimal (optional sign, K suffix) forms are recognized.
// Master stream: one transaction per token, issued for its last character:
// m_axis_tuser_o carries the status, m_axis_tdata_o the value and the
// offending character. Non-last characters produce no output.
// The result is registered in the output register when the last character is taken.
// Throughput: one character per cycle unless stalled; the per-character update
// (shift or multiply by ten plus add) and the final scale and negate sit between
// the scanner state registers and the output register.
// A stalled receiver holds the output register; input is still taken while
// the pending result is being accepted in the same cycle, and otherwise only
// non-last characters are taken; the last character of a token waits.
// Reset returns the scanner to the start of a token and drops any pending
// result.
module numeric_literal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] token_char
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] value, [39:32] bad_char
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);
  import nlp_pkg::*;

  logic    step;
  logic    blocked;
  logic    out_valid_q, out_valid_d;
  result_t out_q, res;

  // stall only a completing token while an older result is still pending
  assign blocked         = out_valid_q && !m_axis_tready_i && s_axis_tlast_i;
  assign s_axis_tready_o = !blocked;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  nlp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .char_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .result_o(res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (step && s_axis_tlast_i) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s_axis_tlast_i) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.bad_char, out_q.value};
  assign m_axis_tuser_o  = out_q.status;

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result lost under stall");
  a_bad_char_only_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_LETTER |-> out_q.bad_char == '0)
    else $error("bad_char set without letter status");
  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.value == '0)
    else $error("value set on error status");
`endif

endmodule

// File: rtl/nlp_core.sv
module nlp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output nlp_pkg::result_t result_o
);
  import nlp_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  status_e     status_q, status_d;
  logic [7:0]  bad_q, bad_d;
  logic        kilo_q, kilo_d;
  logic        neg_q, neg_d;

  logic [7:0]  upc;
  logic        is_dig, is_alpha;
  logic [4:0]  pos_n;
  logic [31:0] val;
  status_e     st;

  always_comb begin
    upc      = char_i & CASE_MASK;
    is_dig   = char_i inside {[8'h30:8'h39]};
    is_alpha = (upc inside {[8'h41:8'h5A]}) || (char_i == CH_USCORE);
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    status_d = status_q;
    bad_d    = bad_q;
    kilo_d   = kilo_q;
    neg_d    = neg_q;
    pos_n    = pos_q;
    val      = '0;
    st       = ST_OK;
    result_o = '0;

    if (step_i && status_q == ST_OK) begin
      case (phase_q)
        PH_START: begin
          if (char_i == CH_DOLLAR) begin
            phase_d = PH_HEX;
            pos_n   = 5'd1;
          end else if (char_i == CH_ZERO) begin
            phase_d = PH_ZERO_U;
          end else if (char_i == CH_PCT) begin
            phase_d = PH_BIN;
          end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
            phase_d = PH_SIGN;
            neg_d   = (char_i == CH_MINUS);
          end else if (is_dig) begin
            acc_d   = {24'd0, char_i - CH_ZERO};
            phase_d = PH_DEC;
          end else begin
            status_d = ST_NOTNUM;
            bad_d    = '0;
          end
        end
        PH_SIGN: begin
          if (char_i == CH_DOLLAR) begin
            phase_d = PH_HEX;
          end else if (char_i == CH_ZERO) begin
            phase_d = PH_ZERO_S;
          end else if (is_dig) begin
            acc_d   = {24'd0, char_i - CH_ZERO};
            phase_d = PH_DEC;
          end else begin
            status_d = ST_SIGN;
            bad_d    = '0;
          end
        end
        PH_ZERO_U, PH_ZERO_S, PH_DEC: begin
          if (phase_q != PH_DEC && char_i == CH_X) begin
            phase_d = PH_HEX;
          end else if (pos_q == DEC_LIMIT) begin
            status_d = ST_LONG;
            bad_d    = '0;
          end else if (is_alpha) begin
            if (char_i == CH_K_UP || char_i == CH_K_LO) begin
              kilo_d  = 1'b1;
              phase_d = PH_KILO;
            end else begin
              status_d = ST_LETTER;
              bad_d    = char_i;
            end
          end else begin
            // non-digit filler still adds its wrapped offset
            acc_d   = (acc_q << 3) + (acc_q << 1) + {{24{1'b0}}, char_i}
                      - {24'd0, CH_ZERO};
            phase_d = PH_DEC;
          end
        end
        PH_HEX: begin
          if (pos_q == HEX_LIMIT) begin
            status_d = ST_LONG;
            bad_d    = '0;
          end else begin
            acc_d = acc_q << 4;
            if (is_dig) begin
              acc_d[3:0] = char_i[3:0];
            end else if (upc inside {[8'h41:8'h46]}) begin
              acc_d[3:0] = upc[3:0] + 4'd9;
            end else if (is_alpha) begin
              status_d = ST_LETTER;
              bad_d    = char_i;
            end
          end
        end
        PH_BIN: begin
          if (pos_q == 5'd1 && !is_dig) begin
            status_d = ST_PERCENT;
            bad_d    = '0;
          end else if (pos_q == BIN_LIMIT) begin
            status_d = ST_LONG;
            bad_d    = '0;
          end else begin
            acc_d = {acc_q[30:0], char_i == CH_ONE};
            if (char_i != CH_ONE && char_i != CH_ZERO) begin
              status_d = ST_BADBIN;
              bad_d    = '0;
            end
          end
        end
        default: begin
          // anything after K
          status_d = ST_LETTER;
          bad_d    = char_i;
        end
      endcase
      pos_d = (pos_n < POS_MAX) ? pos_n + 5'd1 : pos_n;
    end

    if (step_i && last_i) begin
      st = status_d;
      if (st == ST_OK) begin
        if (phase_d == PH_SIGN) begin
          st = ST_SIGN;
        end else if (phase_d == PH_BIN && pos_d == 5'd1) begin
          st = ST_PERCENT;
        end else begin
          val = kilo_d ? (acc_d << KILO_SHIFT) : acc_d;
          if (neg_d) val = 32'd0 - val;
        end
      end
      result_o.status   = st;
      result_o.value    = (st == ST_OK) ? val : '0;
      result_o.bad_char = (st == ST_LETTER) ? bad_d : '0;
      // clear for the next token
      phase_d  = PH_START;
      pos_d    = '0;
      acc_d    = '0;
      status_d = ST_OK;
      bad_d    = '0;
      kilo_d   = 1'b0;
      neg_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      pos_q    <= '0;
      acc_q    <= '0;
      status_q <= ST_OK;
      bad_q    <= '0;
      kilo_q   <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      status_q <= status_d;
      bad_q    <= bad_d;
      kilo_q   <= kilo_d;
      neg_q    <= neg_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PH_START && pos_q == '0 && status_q == ST_OK)
    else $error("token state not cleared after last character");
  a_error_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && status_q != ST_OK |=> $stable(acc_q) && $stable(status_q))
    else $error("state moved after a latched error");
  a_kilo_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kilo_q |-> phase_q == PH_KILO)
    else $error("kilo flag set outside kilo phase");
`endif

endmodule
